@@ sv/float_exp_exp2_unit_core_defines.svh @@
// Assertion macros shared by the exponential unit.
`ifndef FLOAT_EXP_EXP2_UNIT_CORE_DEFINES_SVH
`define FLOAT_EXP_EXP2_UNIT_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define FEXP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define FEXP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fexp_pkg.sv @@
package fexp_pkg;

  // Input and result words
  typedef struct packed {
    logic        func;
    logic [31:0] operand_bits;
  } fexp_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        overflowed;
    logic        underflowed;
  } fexp_out_t;

  // Operand class decided by the front end
  typedef enum logic [1:0] {
    CLS_NORM = 2'd0,
    CLS_NAN  = 2'd1,
    CLS_OVF  = 2'd2,
    CLS_UNF  = 2'd3
  } cls_t;

  typedef struct packed {
    logic        func;
    cls_t        cls;
    logic [31:0] x;
  } qword_t;

  typedef struct packed {
    logic   valid;
    qword_t word;
  } qpush_t;

  // Queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Unrounded float: value = m * 2^(e - 300)
  typedef struct packed {
    logic               sign;
    logic signed [11:0] e;
    logic [49:0]        m;
  } fp_raw_t;

  typedef struct packed {
    logic               func;
    cls_t               cls;
    logic [31:0]        x;
    logic signed [9:0]  k;
    logic [31:0]        zk;
    logic [31:0]        f;
    logic [31:0]        y;
    fp_raw_t            raw;
  } bk_t;

  // Back pipeline: seven setup stages and two per polynomial step
  localparam int NSTEP = 7;
  localparam int NST   = 7 + 2 * NSTEP;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] QNAN_BIT  = 32'h0040_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
  localparam logic [31:0] LOG2E     = 32'h3FB8_AA3B;
  localparam logic [31:0] LN2_HI    = 32'h3F31_8000;
  localparam logic [31:0] LN2_LO    = 32'hB95E_8083;
  localparam logic [31:0] EXP_HI    = 32'h42B1_7218;
  localparam logic [31:0] EXP_LO    = 32'hC2CE_8ED0;
  localparam logic [31:0] EXP2_HI   = 32'h42FE_0000;
  localparam logic [31:0] EXP2_LO   = 32'hC2FE_0000;
  localparam logic [31:0] EXP_TOP   = 32'h3950_6967;

  // Coefficients added at each polynomial step, highest order first
  localparam logic [31:0] EXP_ADD [NSTEP] = '{
    32'h3AB7_43CE, 32'h3C08_8908, 32'h3D2A_A9C1, 32'h3E2A_AAAA,
    32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000
  };
  localparam logic [31:0] EXP2_ADD [NSTEP] = '{
    32'h3920_FDDE, 32'h3AAF_9F29, 32'h3C1D_96A6, 32'h3D63_5774,
    32'h3E75_FDEE, 32'h3F31_7218, 32'h3F80_0000
  };

  // Ordered key for comparing non-NaN floats
  function automatic logic [31:0] fp_key(logic [31:0] v);
    fp_key = v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  // Exact product, rounding left to fp_norm
  function automatic fp_raw_t fp_mul_a(logic [31:0] a, logic [31:0] b);
    fp_raw_t     r;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p = 48'(ma) * 48'(mb);
    r.sign = a[31] ^ b[31];
    r.e = 12'(ea) + 12'(eb);
    r.m = {2'b00, p};
    return r;
  endfunction

  // Aligned sum with guard, round and sticky bits
  function automatic fp_raw_t fp_add_a(logic [31:0] a, logic [31:0] b);
    fp_raw_t     r;
    logic [31:0] bg, sm;
    logic [7:0]  eg, es, d;
    logic [23:0] mg, ms;
    logic [53:0] shf;
    logic [26:0] big3, sml3;
    logic [27:0] sum;
    if (a[30:0] >= b[30:0]) begin
      bg = a;
      sm = b;
    end else begin
      bg = b;
      sm = a;
    end
    eg = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    mg = {bg[30:23] != 8'd0, bg[22:0]};
    ms = {sm[30:23] != 8'd0, sm[22:0]};
    d = eg - es;
    shf = {ms, 30'd0} >> d;
    if (d >= 8'd27) begin
      sml3 = {26'd0, |ms};
    end else begin
      sml3 = shf[53:27] | {26'd0, |shf[26:0]};
    end
    big3 = {mg, 3'b000};
    if (a[31] ^ b[31]) begin
      sum = {1'b0, big3} - {1'b0, sml3};
    end else begin
      sum = {1'b0, big3} + {1'b0, sml3};
    end
    r.sign = (sum == 28'd0) ? (a[31] & b[31]) : bg[31];
    r.e = 12'(eg) + 12'd147;
    r.m = {22'd0, sum};
    return r;
  endfunction

  // Normalize and round to nearest even, subnormals included
  function automatic logic [31:0] fp_norm(fp_raw_t r);
    logic [5:0]         l;
    logic signed [12:0] er, shn;
    logic [5:0]         sa;
    logic [63:0]        mx, q64, mask;
    logic               guard, sticky, rnd, ovf;
    logic [7:0]         base;
    logic [31:0]        tot;
    l = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (r.m[i]) l = 6'(i);
    end
    er = 13'(l) + 13'(r.e) - 13'sd173;
    mx = {14'd0, r.m};
    guard = 1'b0;
    sticky = 1'b0;
    sa = 6'd0;
    ovf = 1'b0;
    mask = 64'd0;
    if (er >= 13'sd1) begin
      shn = 13'(l) - 13'sd23;
      ovf = (er >= 13'sd255);
      base = 8'(er - 13'sd1);
    end else begin
      shn = 13'sd151 - 13'(r.e);
      base = 8'd0;
    end
    if (shn < 13'sd0) begin
      q64 = mx << 6'(-shn);
    end else begin
      sa = (shn > 13'sd63) ? 6'd63 : 6'(shn);
      q64 = mx >> sa;
      if (sa != 6'd0) begin
        guard = mx[sa - 6'd1];
        mask = (64'd1 << (sa - 6'd1)) - 64'd1;
        sticky = |(mx & mask);
      end
    end
    rnd = guard & (sticky | q64[0]);
    tot = (32'(base) << 23) + 32'(q64[23:0]) + 32'(rnd);
    if (ovf || tot >= INF_BITS) tot = INF_BITS;
    if (r.m == 50'd0) tot = 32'd0;
    return {r.sign, tot[30:0]};
  endfunction

  // Float to integer, ties to even; magnitude is known to be small
  function automatic logic signed [9:0] fp_round_int(logic [31:0] v);
    logic [7:0]  s;
    logic [24:0] m, q, mask;
    logic        guard, sticky;
    logic [9:0]  mag;
    m = {1'b0, v[30:23] != 8'd0, v[22:0]};
    s = (v[30:23] >= 8'd150) ? 8'd0 : 8'd150 - v[30:23];
    mag = 10'd0;
    if (v[30:23] != 8'd0 && s <= 8'd25) begin
      q = m >> s;
      guard = 1'b0;
      sticky = 1'b0;
      if (s != 8'd0) begin
        guard = m[5'(s - 8'd1)];
        mask = (25'd1 << (s - 8'd1)) - 25'd1;
        sticky = |(m & mask);
      end
      mag = 10'(q) + 10'(guard & (sticky | q[0]));
    end
    return v[31] ? -$signed(mag) : $signed(mag);
  endfunction

  // Exact integer to float
  function automatic logic [31:0] fp_from_int(logic signed [9:0] k);
    logic [8:0]  a;
    logic [3:0]  l;
    logic [31:0] sh;
    a = k[9] ? 9'(-k) : 9'(k);
    l = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (a[i]) l = 4'(i);
    end
    sh = 32'(a) << (5'd23 - 5'(l));
    if (a == 9'd0) return 32'd0;
    return {k[9], 8'd127 + 8'(l), sh[22:0]};
  endfunction

  // Multiply a normal float by 2^k on the exponent field
  function automatic logic [31:0] fp_scale(logic [31:0] y, logic signed [9:0] k);
    logic signed [10:0] ne;
    logic [10:0]        s;
    logic [23:0]        m, q, mask;
    logic               guard, sticky;
    if (y[30:23] == 8'd0 || y[30:23] == 8'd255) return y;
    ne = $signed({3'b000, y[30:23]}) + 11'(k);
    if (ne >= 11'sd255) return {y[31], INF_BITS[30:0]};
    if (ne >= 11'sd1) return {y[31], ne[7:0], y[22:0]};
    s = 11'(11'sd1 - ne);
    if (s > 11'd25) return {y[31], 31'd0};
    m = {1'b1, y[22:0]};
    q = m >> s;
    guard = m[5'(s - 11'd1)];
    mask = (24'd1 << (s - 11'd1)) - 24'd1;
    sticky = |(m & mask);
    q = q + 24'(guard & (sticky | q[0]));
    return {y[31], 7'd0, q};
  endfunction

endpackage

@@ sv/float_exp_exp2_unit_core.sv @@
// Channel   Handshake          Payload
// input     start / busy       in_data  (func, operand_bits)
// result    out_valid strobe   out_data (result_bits, overflowed, underflowed)
//
// One operand per cycle; each result passes the front register, the queue,
// 21 back stages and the result register.
// The back pipeline advances every cycle, so the queue drains as it fills
// and busy stays low in operation.
// rst_n is synchronous and clears the valid flags and queue pointers.
// The receiver cannot stall: each strobe is taken in its cycle.
`include "float_exp_exp2_unit_core_defines.svh"

module float_exp_exp2_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fexp_pkg::fexp_in_t  in_data,
  output logic                out_valid,
  output fexp_pkg::fexp_out_t out_data
);

  fexp_pkg::qpush_t push, pop;
  logic             q_full;

  fexp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push)
  );

  fexp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .pop    (pop)
  );

  fexp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Overflow flag always comes with +infinity
  `FEXP_ASSERT_NOW(a_ovf_inf, out_valid && out_data.overflowed, out_data.result_bits == fexp_pkg::INF_BITS && !out_data.underflowed, "overflow without +inf")
  // Underflow flag always comes with +0
  `FEXP_ASSERT_NOW(a_unf_zero, out_valid && out_data.underflowed, out_data.result_bits == fexp_pkg::ZERO_BITS, "underflow without +0")
  // The back end drains the queue, so the unit never pushes back
  `FEXP_ASSERT_NOW(a_no_busy, 1'b1, !busy, "unit stalled its input")
  // A queued word leaves the queue on the following cycle
  `FEXP_ASSERT_NEXT(a_drain, push.valid, pop.valid, "queue did not drain")

endmodule

@@ sv/fexp_front.sv @@
module fexp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fexp_pkg::fexp_in_t in_data,
  input  logic              q_full,
  output logic              busy,
  output fexp_pkg::qpush_t  push
);

  logic             front_valid_r, front_valid_nxt;
  fexp_pkg::qword_t front_word_r, front_word_nxt;
  logic             accept, push_ok;
  logic [31:0]      hi, lo, xb;

  assign push_ok = front_valid_r && !q_full;
  assign busy    = front_valid_r && q_full;
  assign accept  = start && !busy;
  assign xb      = in_data.operand_bits;

  // Classify the operand against the limits of the chosen function
  always_comb begin
    hi = in_data.func ? fexp_pkg::EXP2_HI : fexp_pkg::EXP_HI;
    lo = in_data.func ? fexp_pkg::EXP2_LO : fexp_pkg::EXP_LO;
    front_word_nxt.func = in_data.func;
    front_word_nxt.x = xb;
    if (xb[30:23] == 8'hFF && xb[22:0] != 23'd0) begin
      front_word_nxt.cls = fexp_pkg::CLS_NAN;
    end else if (fexp_pkg::fp_key(xb) > fexp_pkg::fp_key(hi)) begin
      front_word_nxt.cls = fexp_pkg::CLS_OVF;
    end else if (fexp_pkg::fp_key(xb) < fexp_pkg::fp_key(lo)) begin
      front_word_nxt.cls = fexp_pkg::CLS_UNF;
    end else begin
      front_word_nxt.cls = fexp_pkg::CLS_NORM;
    end
  end

  // Hold the word until the queue takes it
  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push_ok) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_word_r <= front_word_nxt;
    end
  end

  assign push.valid = push_ok;
  assign push.word  = front_word_r;

endmodule

@@ sv/fexp_queue.sv @@
module fexp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  fexp_pkg::qpush_t push,
  output logic             q_full,
  output fexp_pkg::qpush_t pop
);

  fexp_pkg::qword_t             mem_r [fexp_pkg::QDEPTH];
  logic [fexp_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [fexp_pkg::QAW:0]       cnt_r, cnt_nxt;
  logic                         do_pop;

  // The back end never stalls: drain one word per cycle
  assign do_pop    = (cnt_r != '0);
  assign q_full    = (cnt_r == (fexp_pkg::QAW + 1)'(fexp_pkg::QDEPTH));
  assign pop.valid = do_pop;
  assign pop.word  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (fexp_pkg::QAW)'(push.valid);
    rd_ptr_nxt = rd_ptr_r + (fexp_pkg::QAW)'(do_pop);
    cnt_nxt = cnt_r + (fexp_pkg::QAW + 1)'(push.valid) - (fexp_pkg::QAW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.word;
    end
  end

endmodule

@@ sv/fexp_back.sv @@
module fexp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fexp_pkg::qpush_t    q_in,
  output logic                out_valid,
  output fexp_pkg::fexp_out_t out_data
);

  fexp_pkg::bk_t        st_r   [fexp_pkg::NST];
  fexp_pkg::bk_t        st_nxt [fexp_pkg::NST];
  logic [fexp_pkg::NST-1:0] vld_r;
  logic                 out_valid_r;
  fexp_pkg::fexp_out_t  out_data_r, out_data_nxt;
  logic [31:0]          yfin;

  // Range reduction, then the polynomial in Horner form
  always_comb begin
    logic [31:0] t, zk, yin, c;
    st_nxt[0] = st_r[0];
    st_nxt[0].func = q_in.word.func;
    st_nxt[0].cls = q_in.word.cls;
    st_nxt[0].x = q_in.word.x;
    st_nxt[0].raw = fexp_pkg::fp_mul_a(q_in.word.x, fexp_pkg::LOG2E);

    st_nxt[1] = st_r[0];
    t = fexp_pkg::fp_norm(st_r[0].raw);
    st_nxt[1].k = fexp_pkg::fp_round_int(st_r[0].func ? st_r[0].x : t);

    st_nxt[2] = st_r[1];
    zk = fexp_pkg::fp_from_int(st_r[1].k);
    st_nxt[2].zk = zk;
    st_nxt[2].raw = fexp_pkg::fp_mul_a(zk,
                      st_r[1].func ? fexp_pkg::ONE_BITS : fexp_pkg::LN2_HI);

    st_nxt[3] = st_r[2];
    st_nxt[3].raw = fexp_pkg::fp_add_a(st_r[2].x,
                      fexp_pkg::fp_norm(st_r[2].raw) ^ fexp_pkg::SIGN_BIT);

    st_nxt[4] = st_r[3];
    st_nxt[4].f = fexp_pkg::fp_norm(st_r[3].raw);
    st_nxt[4].raw = fexp_pkg::fp_mul_a(st_r[3].zk,
                      st_r[3].func ? fexp_pkg::ZERO_BITS : fexp_pkg::LN2_LO);

    st_nxt[5] = st_r[4];
    st_nxt[5].raw = fexp_pkg::fp_add_a(st_r[4].f,
                      fexp_pkg::fp_norm(st_r[4].raw) ^ fexp_pkg::SIGN_BIT);

    st_nxt[6] = st_r[5];
    st_nxt[6].f = fexp_pkg::fp_norm(st_r[5].raw);
    st_nxt[6].y = st_r[5].func ? fexp_pkg::ZERO_BITS : fexp_pkg::EXP_TOP;

    // Each step: multiply by f, then add the next coefficient
    for (int j = 0; j < fexp_pkg::NSTEP; j++) begin
      yin = (j == 0) ? st_r[6].y : fexp_pkg::fp_norm(st_r[6 + 2 * j].raw);
      st_nxt[7 + 2 * j] = st_r[6 + 2 * j];
      st_nxt[7 + 2 * j].raw = fexp_pkg::fp_mul_a(yin, st_r[6 + 2 * j].f);
      c = st_r[7 + 2 * j].func ? fexp_pkg::EXP2_ADD[j] : fexp_pkg::EXP_ADD[j];
      st_nxt[8 + 2 * j] = st_r[7 + 2 * j];
      st_nxt[8 + 2 * j].raw = fexp_pkg::fp_add_a(
                                fexp_pkg::fp_norm(st_r[7 + 2 * j].raw), c);
    end
  end

  // Scale by 2^k and pick the special results
  always_comb begin
    yfin = fexp_pkg::fp_norm(st_r[fexp_pkg::NST-1].raw);
    out_data_nxt.overflowed = 1'b0;
    out_data_nxt.underflowed = 1'b0;
    case (st_r[fexp_pkg::NST-1].cls)
      fexp_pkg::CLS_NAN: begin
        out_data_nxt.result_bits = st_r[fexp_pkg::NST-1].x | fexp_pkg::QNAN_BIT;
      end
      fexp_pkg::CLS_OVF: begin
        out_data_nxt.result_bits = fexp_pkg::INF_BITS;
        out_data_nxt.overflowed = 1'b1;
      end
      fexp_pkg::CLS_UNF: begin
        out_data_nxt.result_bits = fexp_pkg::ZERO_BITS;
        out_data_nxt.underflowed = 1'b1;
      end
      default: begin
        out_data_nxt.result_bits = fexp_pkg::fp_scale(yfin, st_r[fexp_pkg::NST-1].k);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[fexp_pkg::NST-2:0], q_in.valid};
      out_valid_r <= vld_r[fexp_pkg::NST-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < fexp_pkg::NST; i++) begin
      st_r[i] <= st_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/tb_float_exp_exp2_unit_core.sv @@
module tb_float_exp_exp2_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 600;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  // Binary32 constants used by the exponential prediction
  localparam bit [31:0] F_LOG2E    = 32'h3FB8_AA3B;
  localparam bit [31:0] F_LN2_HI   = 32'h3F31_8000;
  localparam bit [31:0] F_LN2_LO   = 32'hB95E_8083;
  localparam bit [31:0] F_E_HI     = 32'h42B1_7218;
  localparam bit [31:0] F_E_LO     = 32'hC2CE_8ED0;
  localparam bit [31:0] F_TWO_HI   = 32'h42FE_0000;
  localparam bit [31:0] F_TWO_LO   = 32'hC2FE_0000;
  localparam bit [31:0] F_INF      = 32'h7F80_0000;
  localparam bit [31:0] F_QUIET    = 32'h0040_0000;

  // e^x coefficients, constant term first
  localparam bit [31:0] E_COEF [8] = '{
    32'h3F80_0000, 32'h3F80_0000, 32'h3F00_0000, 32'h3E2A_AAAA,
    32'h3D2A_A9C1, 32'h3C08_8908, 32'h3AB7_43CE, 32'h3950_6967
  };
  // 2^x coefficients, constant term first
  localparam bit [31:0] TWO_COEF [7] = '{
    32'h3F80_0000, 32'h3F31_7218, 32'h3E75_FDEE, 32'h3D63_5774,
    32'h3C1D_96A6, 32'h3AAF_9F29, 32'h3920_FDDE
  };

  typedef struct {
    bit        func;
    bit [31:0] x;
    bit        typed;
    bit [31:0] res;
    bit        ovf;
    bit        unf;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fexp_pkg::fexp_in_t  in_data;
  logic                out_valid;
  fexp_pkg::fexp_out_t out_data;

  fexp_pkg::fexp_out_t expected_q[$];
  int        errors;
  int        words_in;
  int        words_out;
  int        stall_cnt;
  int        n_ovf;
  int        n_unf;
  int        n_nan;
  int        n_sub;
  int        dir_idx;
  row_t      directed[$];

  float_exp_exp2_unit_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Round m * 2^e to binary32, nearest even, subnormals included
  function automatic bit [31:0] f_round(bit s, bit [63:0] m, int e);
    int         l;
    int         be;
    int         sh;
    bit [127:0] mm;
    bit [127:0] q;
    bit [127:0] rem;
    bit [127:0] half;
    bit         up;
    bit [31:0]  tot;
    if (m == 64'd0) return {s, 31'd0};
    l = 0;
    for (int i = 0; i < 64; i++) if (m[i]) l = i;
    be = l + e + 127;
    sh = (be >= 1) ? l - 23 : -149 - e;
    mm = 128'(m);
    up = 1'b0;
    if (sh <= 0) begin
      q = mm << (-sh);
    end else if (sh > 100) begin
      q = '0;
    end else begin
      q = mm >> sh;
      rem = mm & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      up = (rem > half) || (rem == half && q[0]);
    end
    tot = ((be >= 1) ? (32'(be - 1) << 23) : 32'd0) + 32'(q) + 32'(up);
    if (be >= 255 || tot >= F_INF) tot = F_INF;
    return {s, tot[30:0]};
  endfunction

  function automatic bit [31:0] f_mul(bit [31:0] a, bit [31:0] b);
    int        ea;
    int        eb;
    bit [23:0] ma;
    bit [23:0] mb;
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    return f_round(a[31] ^ b[31], 64'(ma) * 64'(mb), ea + eb - 300);
  endfunction

  // Sum with 39 extra bits, sticky folded into the lowest of them
  function automatic bit [31:0] f_add(bit [31:0] a, bit [31:0] b);
    bit [31:0] bg;
    bit [31:0] sm;
    int        eg;
    int        es;
    int        d;
    bit [63:0] big;
    bit [63:0] full;
    bit [63:0] lit;
    bit [63:0] sum;
    if (a[30:0] >= b[30:0]) begin
      bg = a;
      sm = b;
    end else begin
      bg = b;
      sm = a;
    end
    eg = (bg[30:23] == 0) ? 1 : int'(bg[30:23]);
    es = (sm[30:23] == 0) ? 1 : int'(sm[30:23]);
    d = eg - es;
    big = {1'b0, bg[30:23] != 0, bg[22:0], 39'd0};
    full = {1'b0, sm[30:23] != 0, sm[22:0], 39'd0};
    if (d >= 64) begin
      lit = 64'(full != 0);
    end else begin
      lit = full >> d;
      if ((full & ((64'd1 << d) - 64'd1)) != 0) lit[0] = 1'b1;
    end
    sum = (a[31] ^ b[31]) ? big - lit : big + lit;
    if (sum == 0) return {a[31] & b[31], 31'd0};
    return f_round(bg[31], sum, eg - 150 - 39);
  endfunction

  function automatic bit [31:0] f_sub(bit [31:0] a, bit [31:0] b);
    return f_add(a, {~b[31], b[30:0]});
  endfunction

  // Nearest integer, ties to even; magnitude is small here
  function automatic int nearest_int(bit [31:0] v);
    bit [23:0] m;
    int        sh;
    int        mag;
    bit [23:0] rem;
    bit [23:0] half;
    if (v[30:23] < 8'd126) return 0;
    m = {1'b1, v[22:0]};
    sh = 150 - int'(v[30:23]);
    if (sh <= 0) begin
      mag = int'(m) << (-sh);
    end else begin
      mag = int'(m >> sh);
      rem = m & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 1);
      if (rem > half || (rem == half && mag[0])) mag++;
    end
    return v[31] ? -mag : mag;
  endfunction

  function automatic bit [31:0] scale_by_pow2(bit [31:0] y, int k);
    int        ne;
    int        sh;
    bit [23:0] m;
    bit [23:0] q;
    bit [23:0] rem;
    bit [23:0] half;
    if (y[30:23] == 0 || y[30:23] == 8'hFF) return y;
    ne = int'(y[30:23]) + k;
    if (ne >= 255) return {y[31], F_INF[30:0]};
    if (ne >= 1) return {y[31], 8'(ne), y[22:0]};
    sh = 1 - ne;
    if (sh > 25) return {y[31], 31'd0};
    m = {1'b1, y[22:0]};
    q = m >> sh;
    rem = m & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return {y[31], 7'd0, q};
  endfunction

  // Ordering key for non-NaN floats
  function automatic longint order_key(bit [31:0] v);
    return v[31] ? -longint'(v[30:0]) : longint'(v[30:0]);
  endfunction

  function automatic fexp_pkg::fexp_out_t exp_predict(fexp_pkg::fexp_in_t w);
    fexp_pkg::fexp_out_t r;
    bit [31:0] x;
    bit [31:0] hi;
    bit [31:0] lo;
    bit [31:0] zk;
    bit [31:0] f;
    bit [31:0] y;
    int        k;
    x = w.operand_bits;
    hi = w.func ? F_TWO_HI : F_E_HI;
    lo = w.func ? F_TWO_LO : F_E_LO;
    r = '0;
    if (x[30:23] == 8'hFF && x[22:0] != 0) begin
      r.result_bits = x | F_QUIET;
    end else if (order_key(x) > order_key(hi)) begin
      r.result_bits = F_INF;
      r.overflowed = 1'b1;
    end else if (order_key(x) < order_key(lo)) begin
      r.underflowed = 1'b1;
    end else if (!w.func) begin
      k = nearest_int(f_mul(F_LOG2E, x));
      zk = f_round(k < 0, 64'(k < 0 ? -k : k), 0);
      f = f_sub(x, f_mul(zk, F_LN2_HI));
      f = f_sub(f, f_mul(zk, F_LN2_LO));
      y = E_COEF[7];
      for (int i = 6; i >= 0; i--) y = f_add(f_mul(y, f), E_COEF[i]);
      r.result_bits = scale_by_pow2(y, k);
    end else begin
      k = nearest_int(x);
      f = f_sub(x, f_round(k < 0, 64'(k < 0 ? -k : k), 0));
      y = TWO_COEF[6];
      for (int i = 5; i >= 0; i--) y = f_add(f_mul(y, f), TWO_COEF[i]);
      r.result_bits = scale_by_pow2(y, k);
    end
    return r;
  endfunction

  // Random operand: mostly in range, with limits, specials and raw noise
  function automatic bit [31:0] rand_operand();
    bit [31:0] v;
    bit [31:0] lims [4];
    lims = '{F_E_HI, F_E_LO, F_TWO_HI, F_TWO_LO};
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      7: v = lims[$urandom_range(0, 3)] + 32'($urandom_range(0, 64)) - 32'd32;
      8: begin
        case ($urandom_range(0, 3))
          0: v = {1'($urandom), 31'd0};
          1: v = {1'($urandom), 8'hFF, 23'd0};
          2: v = {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
          default: v = {1'($urandom), 8'd0, 23'($urandom)};
        endcase
      end
      9: v = {1'($urandom), 8'($urandom_range(0, 99)), 23'($urandom)};
      default: v = {1'($urandom), 8'($urandom_range(100, 133)), 23'($urandom)};
    endcase
    return v;
  endfunction

  // Hand one word to the block; returns once busy is low, with start held so the block takes it
  task automatic send_word(bit func, bit [31:0] x);
    fexp_pkg::fexp_in_t w;
    w.func = func;
    w.operand_bits = x;
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    while (busy) @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= fexp_pkg::fexp_in_t'({$urandom, $urandom});
    end
  endtask

  // Accept input words and check result words
  always @(posedge clk) begin
    fexp_pkg::fexp_out_t exp_w;
    fexp_pkg::fexp_in_t  w;
    if (rst_n) begin
      if (start && !busy) begin
        w = in_data;
        exp_w = exp_predict(w);
        expected_q.push_back(exp_w);
        words_in++;
      end
      if (out_valid) begin
        words_out++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, out_data);
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_data.result_bits !== exp_w.result_bits) begin
            $display("%0t: result_bits expected %h actual %h", $realtime,
                     exp_w.result_bits, out_data.result_bits);
            errors++;
          end
          if (out_data.overflowed !== exp_w.overflowed) begin
            $display("%0t: overflowed expected %b actual %b", $realtime,
                     exp_w.overflowed, out_data.overflowed);
            errors++;
          end
          if (out_data.underflowed !== exp_w.underflowed) begin
            $display("%0t: underflowed expected %b actual %b", $realtime,
                     exp_w.underflowed, out_data.underflowed);
            errors++;
          end
          if (exp_w.overflowed) n_ovf++;
          if (exp_w.underflowed) n_unf++;
          if (exp_w.result_bits[30:23] == 8'hFF && exp_w.result_bits[22:0] != 0) n_nan++;
          if (exp_w.result_bits[30:23] == 0 && exp_w.result_bits[22:0] != 0) n_sub++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Directed words; typed expectations are checked here as well
  always @(posedge clk) begin
    row_t rw;
    if (rst_n && start && !busy && dir_idx < directed.size()) begin
      rw = directed[dir_idx];
      if (rw.typed && {in_data.func, in_data.operand_bits} == {rw.func, rw.x} &&
          exp_predict(in_data) !== fexp_pkg::fexp_out_t'({rw.res, rw.ovf, rw.unf})) begin
        $display("%0t: table row %0d expected %h %b %b actual prediction %h", $realtime,
                 dir_idx, rw.res, rw.ovf, rw.unf, exp_predict(in_data));
        errors++;
      end
      dir_idx++;
    end
  end

  initial begin
    int left;
    int burst;
    errors = 0;
    words_in = 0;
    words_out = 0;
    stall_cnt = 0;
    n_ovf = 0;
    n_unf = 0;
    n_nan = 0;
    n_sub = 0;
    dir_idx = 0;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    directed = '{
      '{0, 32'h0000_0000, 1, 32'h3F80_0000, 0, 0},
      '{0, 32'h8000_0000, 1, 32'h3F80_0000, 0, 0},
      '{1, 32'h0000_0000, 1, 32'h3F80_0000, 0, 0},
      '{0, 32'h7F80_0000, 1, 32'h7F80_0000, 1, 0},
      '{0, 32'hFF80_0000, 1, 32'h0000_0000, 0, 1},
      '{1, 32'h7F80_0000, 1, 32'h7F80_0000, 1, 0},
      '{1, 32'hFF80_0000, 1, 32'h0000_0000, 0, 1},
      '{0, 32'h7FC0_0001, 1, 32'h7FC0_0001, 0, 0},
      '{0, 32'h7F80_0001, 1, 32'h7FC0_0001, 0, 0},
      '{1, 32'hFFA0_0000, 1, 32'hFFE0_0000, 0, 0},
      '{0, 32'h7F7F_FFFF, 1, 32'h7F80_0000, 1, 0},
      '{0, 32'hFF7F_FFFF, 1, 32'h0000_0000, 0, 1},
      '{0, 32'h42B1_7219, 1, 32'h7F80_0000, 1, 0},
      '{0, 32'hC2CE_8ED1, 1, 32'h0000_0000, 0, 1},
      '{1, 32'h42FE_0001, 1, 32'h7F80_0000, 1, 0},
      '{1, 32'hC2FE_0001, 1, 32'h0000_0000, 0, 1},
      '{1, 32'h42FE_0000, 1, 32'h7F00_0000, 0, 0},
      '{1, 32'hC2FE_0000, 1, 32'h0040_0000, 0, 0},
      '{1, 32'h3F80_0000, 1, 32'h4000_0000, 0, 0},
      '{1, 32'hBF80_0000, 1, 32'h3F00_0000, 0, 0},
      '{0, 32'h42B1_7218, 0, 0, 0, 0},
      '{0, 32'hC2CE_8ED0, 0, 0, 0, 0},
      '{0, 32'h0000_0001, 0, 0, 0, 0},
      '{1, 32'h807F_FFFF, 0, 0, 0, 0},
      '{1, 32'h3FC0_0000, 0, 0, 0, 0},
      '{1, 32'h4020_0000, 0, 0, 0, 0},
      '{1, 32'hBF00_0000, 0, 0, 0, 0},
      '{0, 32'h3F80_0000, 0, 0, 0, 0},
      '{0, 32'hC2C8_0000, 0, 0, 0, 0},
      '{1, 32'hC2FD_0000, 0, 0, 0, 0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table, with a short gap every few rows
    foreach (directed[i]) begin
      send_word(directed[i].func, directed[i].x);
      if (i % 7 == 6) idle_cycles($urandom_range(1, 3));
    end

    // Random bursts with random gaps, some back to back
    left = RANDOM_WORDS;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) burst = left;
      repeat (burst) send_word(1'($urandom), rand_operand());
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);

    // Wait until every expected result has been checked, then let the bench idle
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d results: %0d overflow, %0d underflow,",
             words_in, words_out, n_ovf, n_unf);
    $display("%0d NaN and %0d subnormal results across e^x and 2^x", n_nan, n_sub);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fexp_pkg.sv
sv/fexp_front.sv
sv/fexp_queue.sv
sv/fexp_back.sv
sv/float_exp_exp2_unit_core.sv
bench/tb_float_exp_exp2_unit_core.sv
